[hdl/fau_pkg.sv]
// Shared constants and types for the fraction arithmetic unit.
`default_nettype none

package fau_pkg;

  localparam int WORD_BITS_DEF = 32;

  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_RED = 3'd4;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OVF = 2'd1;
  localparam logic [1:0] ST_ZZ  = 2'd2;

  typedef struct packed {
    logic carry;
    logic zero;
  } alu_flags_t;

endpackage

`default_nettype wire

[hdl/fau_mul.sv]
// Registered magnitude multiplier shared by all products of one item.
`default_nettype none

module fau_mul #(
  parameter int WORD_BITS = fau_pkg::WORD_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic [WORD_BITS-1:0]   x,
  input  wire logic [WORD_BITS-1:0]   y,
  output logic      [2*WORD_BITS-1:0] p
);

  always_ff @(posedge clk) begin
    p <= (2*WORD_BITS)'(x) * (2*WORD_BITS)'(y);
  end

endmodule

`default_nettype wire

[hdl/fau_alu.sv]
// Shared wide adder and subtractor used by the sum, GCD and division steps.
`default_nettype none

module fau_alu #(
  parameter int DW = 2 * fau_pkg::WORD_BITS_DEF
) (
  input  wire logic [DW-1:0]    a,
  input  wire logic [DW-1:0]    b,
  input  wire logic             sub,
  output logic      [DW-1:0]    y,
  output fau_pkg::alu_flags_t   flags
);

  logic [DW:0] full;

  assign full        = {1'b0, a} + {1'b0, b ^ {DW{sub}}} + (DW+1)'(sub);
  assign y           = full[DW-1:0];
  assign flags.carry = full[DW];
  assign flags.zero  = (full[DW-1:0] == '0);

endmodule

`default_nettype wire

[hdl/fraction_alu_with_reduce.sv]
// Top level of the fraction arithmetic unit with GCD reduction.
// Arithmetic opcodes form products first, reduce goes straight to reduction and undefined
// opcodes to the result. Reduction adds a check state, a binary GCD loop and, unless the odd
// GCD part is one, two restoring divisions of numerator and denominator by it. Only one item
// is in flight: no new beat is taken until the result loads. Reset clears the sequencer and
// output valid and sets auto_reduce.
`default_nettype none

module fraction_alu_with_reduce #(
  parameter int WORD_BITS = fau_pkg::WORD_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_data,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [2:0]  cmd,
  input  wire logic [31:0] a_num,
  input  wire logic [31:0] a_den,
  input  wire logic [31:0] b_num,
  input  wire logic [31:0] b_den,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic [31:0]      res_num,
  output logic [31:0]      res_den,
  output logic [1:0]       status
);

  localparam int W  = WORD_BITS;
  localparam int MW = 2 * WORD_BITS;
  localparam int CW = $clog2(MW);
  localparam logic [MW-1:0] LIM = MW'(1) << (W - 1);

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_LOAD = 12'b000000000010,
    S_MUL2 = 12'b000000000100,
    S_MUL3 = 12'b000000001000,
    S_MUL4 = 12'b000000010000,
    S_ADD  = 12'b000000100000,
    S_ADD2 = 12'b000001000000,
    S_RED  = 12'b000010000000,
    S_GCD  = 12'b000100000000,
    S_DIVN = 12'b001000000000,
    S_DIVD = 12'b010000000000,
    S_FIN  = 12'b100000000000
  } state_t;

  state_t state;
  logic   auto_reduce;

  logic [2:0]    r_cmd;
  logic [W-1:0]  r_an, r_ad, r_bn, r_bd;
  logic [W-1:0]  an_mag, ad_mag, bn_mag, bd_mag;
  logic          an_s, ad_s, bn_s, bd_s;

  logic [MW-1:0] n_mag, d_mag, t_mag;
  logic          n_neg, d_neg, t_neg;
  logic          zz;
  logic [MW-1:0] gx, gy;
  logic [MW-1:0] dq, drem;
  logic [CW-1:0] cnt;

  logic [W-1:0]  mul_x, mul_y;
  logic [MW-1:0] mul_p;
  logic          p_nz;

  logic [MW-1:0]       alu_a, alu_b, alu_y;
  logic                alu_sub;
  fau_pkg::alu_flags_t alu_f;

  logic   is_addsub, is_sub, is_mul, fin_go, n_fit, d_fit;
  state_t after_arith;
  logic [W-1:0]  n_emit, d_emit;
  logic [MW-1:0] quo;

  assign an_s = r_an[W-1];
  assign ad_s = r_ad[W-1];
  assign bn_s = r_bn[W-1];
  assign bd_s = r_bd[W-1];
  assign an_mag = an_s ? (~r_an + W'(1)) : r_an;
  assign ad_mag = ad_s ? (~r_ad + W'(1)) : r_ad;
  assign bn_mag = bn_s ? (~r_bn + W'(1)) : r_bn;
  assign bd_mag = bd_s ? (~r_bd + W'(1)) : r_bd;

  assign is_addsub   = (r_cmd == fau_pkg::CMD_ADD) || (r_cmd == fau_pkg::CMD_SUB);
  assign is_sub      = (r_cmd == fau_pkg::CMD_SUB);
  assign is_mul      = (r_cmd == fau_pkg::CMD_MUL);
  assign after_arith = auto_reduce ? S_RED : S_FIN;
  assign fin_go      = !rsp_valid || !rsp_stall;
  assign req_stall   = (state != S_IDLE);
  assign p_nz        = (mul_p != '0);
  assign quo         = {dq[MW-2:0], alu_f.carry};

  assign n_fit  = (n_mag[MW-1:W-1] == '0) || (n_neg && (n_mag == LIM));
  assign d_fit  = (d_mag[MW-1:W-1] == '0) || (d_neg && (d_mag == LIM));
  assign n_emit = n_neg ? (~n_mag[W-1:0] + W'(1)) : n_mag[W-1:0];
  assign d_emit = d_neg ? (~d_mag[W-1:0] + W'(1)) : d_mag[W-1:0];

  always_comb begin
    mul_x = an_mag;
    mul_y = bd_mag;
    unique case (state)
      S_LOAD: begin
        mul_x = an_mag;
        mul_y = is_mul ? bn_mag : bd_mag;
      end
      S_MUL2: begin
        mul_x = ad_mag;
        priority if (is_addsub) mul_y = bn_mag;
        else if (is_mul)       mul_y = bd_mag;
        else                   mul_y = bn_mag;
      end
      default: begin
        mul_x = ad_mag;
        mul_y = bd_mag;
      end
    endcase
  end

  always_comb begin
    alu_a   = n_mag;
    alu_b   = t_mag;
    alu_sub = 1'b1;
    unique case (state)
      S_ADD: begin
        alu_a   = n_mag;
        alu_b   = t_mag;
        alu_sub = (n_neg != t_neg);
      end
      S_ADD2: begin
        alu_a = t_mag;
        alu_b = n_mag;
      end
      S_GCD: begin
        alu_a = gy;
        alu_b = gx;
      end
      S_DIVN, S_DIVD: begin
        alu_a = {drem[MW-2:0], dq[MW-1]};
        alu_b = gx;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  fau_mul #(.WORD_BITS(W)) u_mul (
    .clk (clk),
    .x   (mul_x),
    .y   (mul_y),
    .p   (mul_p)
  );

  fau_alu #(.DW(MW)) u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .y     (alu_y),
    .flags (alu_f)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      auto_reduce <= 1'b1;
    end else if (cfg_we) begin
      auto_reduce <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == S_FIN) && fin_go) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            r_cmd <= cmd;
            r_an  <= a_num[W-1:0];
            r_ad  <= a_den[W-1:0];
            r_bn  <= b_num[W-1:0];
            r_bd  <= b_den[W-1:0];
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          n_mag <= MW'(an_mag);
          n_neg <= an_s;
          d_mag <= MW'(ad_mag);
          d_neg <= ad_s;
          zz    <= 1'b0;
          priority if (r_cmd <= fau_pkg::CMD_DIV) state <= S_MUL2;
          else if (r_cmd == fau_pkg::CMD_RED)    state <= S_RED;
          else                                   state <= S_FIN;
        end
        S_MUL2: begin
          n_mag <= mul_p;
          n_neg <= p_nz && (an_s ^ (is_mul ? bn_s : bd_s));
          state <= S_MUL3;
        end
        S_MUL3: begin
          if (is_addsub) begin
            t_mag <= mul_p;
            t_neg <= p_nz && (bn_s ^ ad_s ^ is_sub);
            state <= S_MUL4;
          end else begin
            d_mag <= mul_p;
            d_neg <= p_nz && (ad_s ^ (is_mul ? bd_s : bn_s));
            state <= after_arith;
          end
        end
        S_MUL4: begin
          d_mag <= mul_p;
          d_neg <= p_nz && (ad_s ^ bd_s);
          state <= S_ADD;
        end
        S_ADD: begin
          if (!alu_sub || alu_f.carry) begin
            n_mag <= alu_y;
            n_neg <= n_neg && !alu_f.zero;
            state <= after_arith;
          end else begin
            state <= S_ADD2;
          end
        end
        S_ADD2: begin
          n_mag <= alu_y;
          n_neg <= t_neg;
          state <= after_arith;
        end
        S_RED: begin
          priority if ((n_mag == '0) && (d_mag == '0)) begin
            zz    <= 1'b1;
            state <= S_FIN;
          end else if (n_mag == '0) begin
            d_mag <= MW'(1);
            state <= S_FIN;
          end else if (d_mag == '0) begin
            n_mag <= MW'(1);
            state <= S_FIN;
          end else begin
            gx    <= n_mag;
            gy    <= d_mag;
            state <= S_GCD;
          end
        end
        S_GCD: begin
          priority if (gy == '0) begin
            dq   <= n_mag;
            drem <= '0;
            cnt  <= '0;
            if (gx == MW'(1)) begin
              state <= S_FIN;
            end else begin
              state <= S_DIVN;
            end
          end else if (!gx[0] && !gy[0]) begin
            // Common factors of two come out of the fraction itself here.
            gx    <= gx >> 1;
            gy    <= gy >> 1;
            n_mag <= n_mag >> 1;
            d_mag <= d_mag >> 1;
          end else if (!gx[0]) begin
            gx <= gx >> 1;
          end else if (!gy[0]) begin
            gy <= gy >> 1;
          end else if (alu_f.carry) begin
            gy <= alu_y;
          end else begin
            gx <= gy;
            gy <= gx;
          end
        end
        S_DIVN: begin
          if (cnt == CW'(MW - 1)) begin
            n_mag <= quo;
            dq    <= d_mag;
            drem  <= '0;
            cnt   <= '0;
            state <= S_DIVD;
          end else begin
            drem <= alu_f.carry ? alu_y : alu_a;
            dq   <= quo;
            cnt  <= cnt + CW'(1);
          end
        end
        S_DIVD: begin
          drem <= alu_f.carry ? alu_y : alu_a;
          dq   <= quo;
          cnt  <= cnt + CW'(1);
          if (cnt == CW'(MW - 1)) begin
            d_mag <= quo;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            res_num <= 32'($signed(n_emit));
            res_den <= 32'($signed(d_emit));
            priority if (zz)          status <= fau_pkg::ST_ZZ;
            else if (!n_fit || !d_fit) status <= fau_pkg::ST_OVF;
            else                       status <= fau_pkg::ST_OK;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == S_LOAD))
    else $error("accepted beat did not start the sequencer");

  a_gcd_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_GCD) |-> (gx != '0))
    else $error("GCD loop running with a zero operand");

  a_div_odd: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DIVN) || (state == S_DIVD)) |-> gx[0])
    else $error("divisor is not the odd GCD");

  a_zz_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (status == fau_pkg::ST_ZZ)) |-> ((res_num == '0) && (res_den == '0)))
    else $error("zero over zero flagged on a nonzero result");

endmodule

`default_nettype wire

[tb/tb_fraction_alu_with_reduce.sv]
// Self-checking testbench for the fraction arithmetic unit with directed and random beats.
`timescale 1ns / 1ps

module tb_fraction_alu_with_reduce;

  localparam logic [2:0] CMD_UNDEF_LO = 3'd5;
  localparam logic [2:0] CMD_UNDEF_HI = 3'd7;
  localparam logic [31:0] W_MIN = 32'h8000_0000;
  localparam logic [31:0] W_MAX = 32'h7fff_ffff;
  localparam logic [31:0] W_NEG1 = 32'hffff_ffff;
  localparam int TAIL_CYCLES = 400;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic neg;
    logic [63:0] mag;
  } smag_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [31:0] an, ad, bn, bd;
  } frac_op_t;

  typedef struct packed {
    logic [31:0] num;
    logic [31:0] den;
    logic [1:0] st;
  } frac_res_t;

  typedef struct packed {
    frac_op_t op;
    frac_res_t res;
  } frac_exp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_data = 1'b0;
  logic req_valid = 1'b0;
  logic req_stall;
  logic [2:0] cmd = '0;
  logic [31:0] a_num = '0;
  logic [31:0] a_den = '0;
  logic [31:0] b_num = '0;
  logic [31:0] b_den = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic [31:0] res_num;
  logic [31:0] res_den;
  logic [1:0] status;

  bit auto_reduce_mdl = 1'b1;
  bit idle_en = 1'b1;
  int fail_count = 0;
  frac_exp_t pending_fracs[$];

  fraction_alu_with_reduce u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .cmd(cmd),
    .a_num(a_num),
    .a_den(a_den),
    .b_num(b_num),
    .b_den(b_den),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .res_num(res_num),
    .res_den(res_den),
    .status(status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #80_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic smag_t to_smag(logic [31:0] x);
    smag_t r;
    r.neg = x[31];
    r.mag = x[31] ? {32'd0, ~x + 32'd1} : {32'd0, x};
    return r;
  endfunction

  function automatic smag_t smag_mul(smag_t x, smag_t y);
    smag_t r;
    r.mag = x.mag * y.mag;
    r.neg = (r.mag != 0) && (x.neg != y.neg);
    return r;
  endfunction

  function automatic smag_t smag_add(smag_t x, smag_t y);
    smag_t r;
    if (x.neg == y.neg) begin
      r.mag = x.mag + y.mag;
      r.neg = x.neg;
    end else if (x.mag >= y.mag) begin
      r.mag = x.mag - y.mag;
      r.neg = x.neg;
    end else begin
      r.mag = y.mag - x.mag;
      r.neg = y.neg;
    end
    if (r.mag == 0) r.neg = 1'b0;
    return r;
  endfunction

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic bit fits_word(smag_t x);
    return x.neg ? (x.mag <= 64'h8000_0000) : (x.mag < 64'h8000_0000);
  endfunction

  function automatic frac_res_t fraction_result(frac_op_t op, bit reduce_on);
    smag_t an, ad, bn, bd, n, d, t;
    logic [63:0] g, nv, dv;
    bit do_red;
    frac_res_t r;
    an = to_smag(op.an);
    ad = to_smag(op.ad);
    bn = to_smag(op.bn);
    bd = to_smag(op.bd);
    n = an;
    d = ad;
    do_red = 1'b0;
    case (op.cmd)
      fau_pkg::CMD_ADD, fau_pkg::CMD_SUB: begin
        t = smag_mul(bn, ad);
        if (op.cmd == fau_pkg::CMD_SUB && t.mag != 0) t.neg = !t.neg;
        n = smag_add(smag_mul(an, bd), t);
        d = smag_mul(ad, bd);
        do_red = reduce_on;
      end
      fau_pkg::CMD_MUL: begin
        n = smag_mul(an, bn);
        d = smag_mul(ad, bd);
        do_red = reduce_on;
      end
      fau_pkg::CMD_DIV: begin
        n = smag_mul(an, bd);
        d = smag_mul(ad, bn);
        do_red = reduce_on;
      end
      fau_pkg::CMD_RED: begin
        do_red = 1'b1;
      end
      default: ;
    endcase
    r.st = fau_pkg::ST_OK;
    g = gcd64(n.mag, d.mag);
    if (do_red && g == 0) begin
      r.st = fau_pkg::ST_ZZ;
    end else begin
      if (do_red) begin
        n.mag = n.mag / g;
        d.mag = d.mag / g;
      end
      if (!fits_word(n) || !fits_word(d)) r.st = fau_pkg::ST_OVF;
    end
    nv = n.neg ? 64'd0 - n.mag : n.mag;
    dv = d.neg ? 64'd0 - d.mag : d.mag;
    r.num = nv[31:0];
    r.den = dv[31:0];
    return r;
  endfunction

  always @(posedge clk) begin : rsp_side
    frac_exp_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_fracs.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected result %h/%h status %0d", res_num, res_den, status);
      end else begin
        e = pending_fracs.pop_front();
        if (res_num !== e.res.num || res_den !== e.res.den || status !== e.res.st) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("mismatch cmd %0d a %h/%h b %h/%h: expected %h/%h st %0d, got %h/%h st %0d",
                     e.op.cmd, e.op.an, e.op.ad, e.op.bn, e.op.bd,
                     e.res.num, e.res.den, e.res.st, res_num, res_den, status);
        end
      end
    end
    rsp_stall <= idle_en && ($urandom_range(99) < 38);
  end

  task automatic send_frac(input logic [2:0] c, input logic [31:0] an, ad, bn, bd);
    frac_exp_t e;
    while (idle_en && $urandom_range(99) < 38) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    cmd <= c;
    a_num <= an;
    a_den <= ad;
    b_num <= bn;
    b_den <= bd;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    e.op = {c, an, ad, bn, bd};
    e.res = fraction_result(e.op, auto_reduce_mdl);
    pending_fracs.push_back(e);
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_fracs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_auto_reduce(input bit v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    auto_reduce_mdl = v;
  endtask

  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    int unsigned k;
    k = $urandom_range(9);
    if (k < 4) begin
      w = $urandom_range(48) - 24;
    end else if (k == 4) begin
      case ($urandom_range(5))
        0: w = W_MIN;
        1: w = W_MAX;
        2: w = W_NEG1;
        3: w = 32'd1;
        4: w = W_MIN + 32'd1;
        default: w = 32'd0;
      endcase
    end else if (k < 8) begin
      w = $urandom();
    end else begin
      w = $urandom_range(65535) * ($urandom_range(11) + 1);
      if ($urandom_range(1)) w = -w;
    end
    return w;
  endfunction

  task automatic test_reduced_arith();
    set_auto_reduce(1'b1);
    send_frac(fau_pkg::CMD_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_frac(fau_pkg::CMD_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
    send_frac(fau_pkg::CMD_ADD, 32'd0, 32'd0, 32'd0, 32'd0);
    send_frac(fau_pkg::CMD_MUL, W_MIN, W_MIN, W_MIN, W_MIN);
    send_frac(fau_pkg::CMD_MUL, W_MAX, 32'd1, W_MAX, 32'd1);
    send_frac(fau_pkg::CMD_DIV, 32'd3, 32'd4, 32'd0, 32'd5);
    send_frac(fau_pkg::CMD_DIV, W_MIN, 32'd1, W_NEG1, 32'd1);
    send_frac(fau_pkg::CMD_SUB, W_MAX, 32'd1, W_NEG1, 32'd1);
    send_frac(fau_pkg::CMD_RED, 32'd0, 32'd0, W_NEG1, W_MIN);
    send_frac(fau_pkg::CMD_RED, -32'd6, -32'd4, 32'd0, 32'd0);
    send_frac(fau_pkg::CMD_RED, W_MIN, 32'd2, W_MAX, W_MAX);
    send_frac(fau_pkg::CMD_RED, 32'd0, -32'd7, 32'd1, 32'd1);
    send_frac(fau_pkg::CMD_RED, W_MIN, W_MIN, 32'd0, 32'd0);
  endtask

  task automatic test_raw_arith();
    set_auto_reduce(1'b0);
    send_frac(fau_pkg::CMD_ADD, 32'd1, 32'd2, 32'd1, 32'd2);
    send_frac(fau_pkg::CMD_MUL, W_MIN, W_MAX, W_MIN, W_MAX);
    send_frac(fau_pkg::CMD_SUB, 32'd0, 32'd0, 32'd0, 32'd0);
    send_frac(fau_pkg::CMD_DIV, W_NEG1, W_NEG1, W_MAX, W_MIN);
    send_frac(fau_pkg::CMD_RED, 32'd12, -32'd18, W_NEG1, W_NEG1);
    send_frac(fau_pkg::CMD_RED, 32'd0, 32'd0, 32'd5, 32'd9);
  endtask

  task automatic test_unused_opcodes();
    for (int c = CMD_UNDEF_LO; c <= CMD_UNDEF_HI; c++)
      send_frac(3'(c), W_MIN, W_MAX, W_NEG1, 32'd0);
  endtask

  task automatic test_random_mix(input int count, input bit reduce_on, input bit idle);
    logic [2:0] c;
    logic [31:0] f;
    set_auto_reduce(reduce_on);
    idle_en = idle;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 5) c = 3'($urandom_range(CMD_UNDEF_HI, CMD_UNDEF_LO));
      else c = 3'($urandom_range(fau_pkg::CMD_RED));
      if (c == fau_pkg::CMD_RED && $urandom_range(1)) begin
        f = $urandom_range(4095) + 1;
        send_frac(c, f * ($urandom_range(200) - 100), f * ($urandom_range(200) - 100),
                  $urandom(), $urandom());
      end else begin
        send_frac(c, rand_word(), rand_word(), rand_word(), rand_word());
      end
    end
    idle_en = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reduced_arith();
    test_raw_arith();
    test_unused_opcodes();
    test_random_mix(450, 1'b1, 1'b1);
    test_random_mix(400, 1'b0, 1'b1);
    test_random_mix(300, 1'b1, 1'b0);
    test_random_mix(520, 1'b0, 1'b1);
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_fracs.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[filelist.f]
hdl/fau_pkg.sv
hdl/fau_mul.sv
hdl/fau_alu.sv
hdl/fraction_alu_with_reduce.sv
tb/tb_fraction_alu_with_reduce.sv
